>>> sv/stc_pkg.sv
// Shared types, codes and the micro-program for the T/P/H trim compensation block.
// No dependencies; used by stc_alu and sensor_thp_compensation.
package stc_pkg;

  typedef enum logic [2:0] {
    UOP_ADD, UOP_SUB, UOP_MUL, UOP_ASR, UOP_SHL, UOP_DIV, UOP_END
  } uop_t;

  typedef enum logic [2:0] {
    TGT_NONE, TGT_FINE, TGT_TEMP, TGT_PRESS, TGT_HUM
  } tgt_t;

  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_FETCH, SEQ_ISSUE, SEQ_WAIT, SEQ_OUT
  } seq_st_t;

  typedef enum logic [1:0] {
    AS_IDLE, AS_MUL, AS_DIV
  } alu_st_t;

  typedef struct packed {
    logic       start;
    uop_t       op;
    logic [5:0] sh;
    logic       w32;
  } alu_req_t;

  typedef struct packed {
    uop_t       op;
    logic [3:0] dst;
    logic [5:0] a;
    logic [5:0] b;
    logic [5:0] sh;
    logic       w32;
    tgt_t       tgt;
  } uinst_t;

  // configuration register indexes
  localparam logic [2:0] CFG_TEMP    = 3'd0;
  localparam logic [2:0] CFG_PRESS_A = 3'd1;
  localparam logic [2:0] CFG_PRESS_B = 3'd2;
  localparam logic [2:0] CFG_PRESS_C = 3'd3;
  localparam logic [2:0] CFG_HUM_A   = 3'd4;
  localparam logic [2:0] CFG_HUM_B   = 3'd5;

  localparam logic [19:0] TEMP_SKIP  = 20'h80000;
  localparam logic [19:0] PRESS_SKIP = 20'h80000;
  localparam logic [15:0] HUM_SKIP   = 16'h8000;

  localparam logic [31:0] HUM_MAX    = 32'd419430400;
  localparam logic [16:0] HUM_MAX_Q  = 17'd102400;

  // operand codes: below 16 is a scratch register, 16 and above is a trim word,
  // an input, fine temperature or a constant
  localparam logic [5:0] R0 = 6'd0;
  localparam logic [5:0] R1 = 6'd1;
  localparam logic [5:0] R2 = 6'd2;
  localparam logic [5:0] R3 = 6'd3;
  localparam logic [5:0] R4 = 6'd4;
  localparam logic [5:0] R5 = 6'd5;
  localparam logic [5:0] R6 = 6'd6;
  localparam logic [5:0] R7 = 6'd7;
  localparam logic [5:0] SRC_T1 = 6'd16;
  localparam logic [5:0] SRC_T2 = 6'd17;
  localparam logic [5:0] SRC_T3 = 6'd18;
  localparam logic [5:0] SRC_P1 = 6'd19;
  localparam logic [5:0] SRC_P2 = 6'd20;
  localparam logic [5:0] SRC_P3 = 6'd21;
  localparam logic [5:0] SRC_P4 = 6'd22;
  localparam logic [5:0] SRC_P5 = 6'd23;
  localparam logic [5:0] SRC_P6 = 6'd24;
  localparam logic [5:0] SRC_P7 = 6'd25;
  localparam logic [5:0] SRC_P8 = 6'd26;
  localparam logic [5:0] SRC_P9 = 6'd27;
  localparam logic [5:0] SRC_H1 = 6'd28;
  localparam logic [5:0] SRC_H2 = 6'd29;
  localparam logic [5:0] SRC_H3 = 6'd30;
  localparam logic [5:0] SRC_H4 = 6'd31;
  localparam logic [5:0] SRC_H5 = 6'd32;
  localparam logic [5:0] SRC_H6 = 6'd33;
  localparam logic [5:0] SRC_ADT = 6'd34;
  localparam logic [5:0] SRC_ADP = 6'd35;
  localparam logic [5:0] SRC_ADH = 6'd36;
  localparam logic [5:0] SRC_FINE = 6'd37;
  localparam logic [5:0] SRC_C1 = 6'd38;
  localparam logic [5:0] SRC_C5 = 6'd39;
  localparam logic [5:0] SRC_C128 = 6'd40;
  localparam logic [5:0] SRC_C128000 = 6'd41;
  localparam logic [5:0] SRC_C1048576 = 6'd42;
  localparam logic [5:0] SRC_C3125 = 6'd43;
  localparam logic [5:0] SRC_C76800 = 6'd44;
  localparam logic [5:0] SRC_C2097152 = 6'd45;
  localparam logic [5:0] SRC_C16384 = 6'd46;
  localparam logic [5:0] SRC_C8192 = 6'd47;
  localparam logic [5:0] SRC_C32768 = 6'd48;

  localparam logic [6:0] PC_TEMP  = 7'd0;
  localparam logic [6:0] PC_PRESS = 7'd16;
  localparam logic [6:0] PC_HUM   = 7'd50;

  function automatic uinst_t mk(uop_t op, logic [5:0] d, logic [5:0] a, logic [5:0] b,
                                logic [5:0] sh, logic w, tgt_t t);
    uinst_t u;
    u.op  = op;
    u.dst = d[3:0];
    u.a   = a;
    u.b   = b;
    u.sh  = sh;
    u.w32 = w;
    u.tgt = t;
    return u;
  endfunction

  function automatic uinst_t ucode(logic [6:0] pc);
    uinst_t u;
    case (pc)
      // temperature, 32-bit wrap
      7'd0:  u = mk(UOP_ASR, R0, SRC_ADT, SRC_ADT, 6'd3, 1'b1, TGT_NONE);
      7'd1:  u = mk(UOP_SHL, R1, SRC_T1, SRC_T1, 6'd1, 1'b1, TGT_NONE);
      7'd2:  u = mk(UOP_SUB, R0, R0, R1, 6'd0, 1'b1, TGT_NONE);
      7'd3:  u = mk(UOP_MUL, R0, R0, SRC_T2, 6'd0, 1'b1, TGT_NONE);
      7'd4:  u = mk(UOP_ASR, R0, R0, R0, 6'd11, 1'b1, TGT_NONE);
      7'd5:  u = mk(UOP_ASR, R1, SRC_ADT, SRC_ADT, 6'd4, 1'b1, TGT_NONE);
      7'd6:  u = mk(UOP_SUB, R1, R1, SRC_T1, 6'd0, 1'b1, TGT_NONE);
      7'd7:  u = mk(UOP_MUL, R1, R1, R1, 6'd0, 1'b1, TGT_NONE);
      7'd8:  u = mk(UOP_ASR, R1, R1, R1, 6'd12, 1'b1, TGT_NONE);
      7'd9:  u = mk(UOP_MUL, R1, R1, SRC_T3, 6'd0, 1'b1, TGT_NONE);
      7'd10: u = mk(UOP_ASR, R1, R1, R1, 6'd14, 1'b1, TGT_NONE);
      7'd11: u = mk(UOP_ADD, R0, R0, R1, 6'd0, 1'b1, TGT_FINE);
      7'd12: u = mk(UOP_MUL, R0, R0, SRC_C5, 6'd0, 1'b1, TGT_NONE);
      7'd13: u = mk(UOP_ADD, R0, R0, SRC_C128, 6'd0, 1'b1, TGT_NONE);
      7'd14: u = mk(UOP_ASR, R0, R0, R0, 6'd8, 1'b1, TGT_TEMP);
      7'd15: u = mk(UOP_END, R0, R0, R0, 6'd0, 1'b0, TGT_NONE);
      // pressure, 64-bit wrap
      7'd16: u = mk(UOP_SUB, R0, SRC_FINE, SRC_C128000, 6'd0, 1'b0, TGT_NONE);
      7'd17: u = mk(UOP_MUL, R1, R0, R0, 6'd0, 1'b0, TGT_NONE);
      7'd18: u = mk(UOP_MUL, R2, R1, SRC_P6, 6'd0, 1'b0, TGT_NONE);
      7'd19: u = mk(UOP_MUL, R3, R0, SRC_P5, 6'd0, 1'b0, TGT_NONE);
      7'd20: u = mk(UOP_SHL, R3, R3, R3, 6'd17, 1'b0, TGT_NONE);
      7'd21: u = mk(UOP_ADD, R2, R2, R3, 6'd0, 1'b0, TGT_NONE);
      7'd22: u = mk(UOP_SHL, R3, SRC_P4, SRC_P4, 6'd35, 1'b0, TGT_NONE);
      7'd23: u = mk(UOP_ADD, R2, R2, R3, 6'd0, 1'b0, TGT_NONE);
      7'd24: u = mk(UOP_MUL, R3, R1, SRC_P3, 6'd0, 1'b0, TGT_NONE);
      7'd25: u = mk(UOP_ASR, R3, R3, R3, 6'd8, 1'b0, TGT_NONE);
      7'd26: u = mk(UOP_MUL, R4, R0, SRC_P2, 6'd0, 1'b0, TGT_NONE);
      7'd27: u = mk(UOP_SHL, R4, R4, R4, 6'd12, 1'b0, TGT_NONE);
      7'd28: u = mk(UOP_ADD, R3, R3, R4, 6'd0, 1'b0, TGT_NONE);
      7'd29: u = mk(UOP_SHL, R4, SRC_C1, SRC_C1, 6'd47, 1'b0, TGT_NONE);
      7'd30: u = mk(UOP_ADD, R3, R4, R3, 6'd0, 1'b0, TGT_NONE);
      7'd31: u = mk(UOP_MUL, R3, R3, SRC_P1, 6'd0, 1'b0, TGT_NONE);
      7'd32: u = mk(UOP_ASR, R3, R3, R3, 6'd33, 1'b0, TGT_NONE);
      7'd33: u = mk(UOP_SUB, R4, SRC_C1048576, SRC_ADP, 6'd0, 1'b0, TGT_NONE);
      7'd34: u = mk(UOP_SHL, R4, R4, R4, 6'd31, 1'b0, TGT_NONE);
      7'd35: u = mk(UOP_SUB, R4, R4, R2, 6'd0, 1'b0, TGT_NONE);
      7'd36: u = mk(UOP_MUL, R4, R4, SRC_C3125, 6'd0, 1'b0, TGT_NONE);
      7'd37: u = mk(UOP_DIV, R4, R4, R3, 6'd0, 1'b0, TGT_NONE);
      7'd38: u = mk(UOP_ASR, R5, R4, R4, 6'd13, 1'b0, TGT_NONE);
      7'd39: u = mk(UOP_MUL, R6, SRC_P9, R5, 6'd0, 1'b0, TGT_NONE);
      7'd40: u = mk(UOP_MUL, R6, R6, R5, 6'd0, 1'b0, TGT_NONE);
      7'd41: u = mk(UOP_ASR, R6, R6, R6, 6'd25, 1'b0, TGT_NONE);
      7'd42: u = mk(UOP_MUL, R7, SRC_P8, R4, 6'd0, 1'b0, TGT_NONE);
      7'd43: u = mk(UOP_ASR, R7, R7, R7, 6'd19, 1'b0, TGT_NONE);
      7'd44: u = mk(UOP_ADD, R4, R4, R6, 6'd0, 1'b0, TGT_NONE);
      7'd45: u = mk(UOP_ADD, R4, R4, R7, 6'd0, 1'b0, TGT_NONE);
      7'd46: u = mk(UOP_ASR, R4, R4, R4, 6'd8, 1'b0, TGT_NONE);
      7'd47: u = mk(UOP_SHL, R5, SRC_P7, SRC_P7, 6'd4, 1'b0, TGT_NONE);
      7'd48: u = mk(UOP_ADD, R4, R4, R5, 6'd0, 1'b0, TGT_PRESS);
      7'd49: u = mk(UOP_END, R0, R0, R0, 6'd0, 1'b0, TGT_NONE);
      // humidity, 32-bit wrap
      7'd50: u = mk(UOP_SUB, R0, SRC_FINE, SRC_C76800, 6'd0, 1'b1, TGT_NONE);
      7'd51: u = mk(UOP_SHL, R1, SRC_ADH, SRC_ADH, 6'd14, 1'b1, TGT_NONE);
      7'd52: u = mk(UOP_SHL, R2, SRC_H4, SRC_H4, 6'd20, 1'b1, TGT_NONE);
      7'd53: u = mk(UOP_SUB, R1, R1, R2, 6'd0, 1'b1, TGT_NONE);
      7'd54: u = mk(UOP_MUL, R2, SRC_H5, R0, 6'd0, 1'b1, TGT_NONE);
      7'd55: u = mk(UOP_SUB, R1, R1, R2, 6'd0, 1'b1, TGT_NONE);
      7'd56: u = mk(UOP_ADD, R1, R1, SRC_C16384, 6'd0, 1'b1, TGT_NONE);
      7'd57: u = mk(UOP_ASR, R1, R1, R1, 6'd15, 1'b1, TGT_NONE);
      7'd58: u = mk(UOP_MUL, R2, R0, SRC_H6, 6'd0, 1'b1, TGT_NONE);
      7'd59: u = mk(UOP_ASR, R2, R2, R2, 6'd10, 1'b1, TGT_NONE);
      7'd60: u = mk(UOP_MUL, R3, R0, SRC_H3, 6'd0, 1'b1, TGT_NONE);
      7'd61: u = mk(UOP_ASR, R3, R3, R3, 6'd11, 1'b1, TGT_NONE);
      7'd62: u = mk(UOP_ADD, R3, R3, SRC_C32768, 6'd0, 1'b1, TGT_NONE);
      7'd63: u = mk(UOP_MUL, R2, R2, R3, 6'd0, 1'b1, TGT_NONE);
      7'd64: u = mk(UOP_ASR, R2, R2, R2, 6'd10, 1'b1, TGT_NONE);
      7'd65: u = mk(UOP_ADD, R2, R2, SRC_C2097152, 6'd0, 1'b1, TGT_NONE);
      7'd66: u = mk(UOP_MUL, R2, R2, SRC_H2, 6'd0, 1'b1, TGT_NONE);
      7'd67: u = mk(UOP_ADD, R2, R2, SRC_C8192, 6'd0, 1'b1, TGT_NONE);
      7'd68: u = mk(UOP_ASR, R2, R2, R2, 6'd14, 1'b1, TGT_NONE);
      7'd69: u = mk(UOP_MUL, R1, R1, R2, 6'd0, 1'b1, TGT_NONE);
      7'd70: u = mk(UOP_ASR, R3, R1, R1, 6'd15, 1'b1, TGT_NONE);
      7'd71: u = mk(UOP_MUL, R3, R3, R3, 6'd0, 1'b1, TGT_NONE);
      7'd72: u = mk(UOP_ASR, R3, R3, R3, 6'd7, 1'b1, TGT_NONE);
      7'd73: u = mk(UOP_MUL, R3, R3, SRC_H1, 6'd0, 1'b1, TGT_NONE);
      7'd74: u = mk(UOP_ASR, R3, R3, R3, 6'd4, 1'b1, TGT_NONE);
      7'd75: u = mk(UOP_SUB, R1, R1, R3, 6'd0, 1'b1, TGT_HUM);
      default: u = mk(UOP_END, R0, R0, R0, 6'd0, 1'b0, TGT_NONE);
    endcase
    return u;
  endfunction

endpackage

>>> sv/stc_alu.sv
// Shared 64-bit arithmetic unit: add, subtract, shifts, wrapping multiply on one
// 32x32 multiplier, signed divide one quotient bit a cycle.
// Depends on stc_pkg.
module stc_alu (
  input  logic                clk,
  input  logic                rst_n,
  input  stc_pkg::alu_req_t   req,
  input  logic [63:0]         opa,
  input  logic [63:0]         opb,
  output logic                done,
  output logic [63:0]         result
);

  stc_pkg::alu_st_t st_r, st_nxt;
  logic [63:0] a_r, b_r, prod_r, acc_r, q_r, rem_r, mb_r, res_r;
  logic [5:0]  cnt_r;
  logic        neg_r, w32_r, done_r;
  logic [31:0] mx, my;
  logic [63:0] mul_p, simple_res, rem_sh, q_sh, acc_fin, q_fin;
  logic        ge;

  function automatic logic [63:0] fix(logic [63:0] r, logic w);
    return w ? {{32{r[31]}}, r[31:0]} : r;
  endfunction

  always_comb begin
    case (st_r)
      stc_pkg::AS_IDLE: begin
        if (req.start && req.op == stc_pkg::UOP_MUL) begin
          st_nxt = stc_pkg::AS_MUL;
        end else if (req.start && req.op == stc_pkg::UOP_DIV) begin
          st_nxt = stc_pkg::AS_DIV;
        end else begin
          st_nxt = stc_pkg::AS_IDLE;
        end
      end
      stc_pkg::AS_MUL: st_nxt = (cnt_r == 6'd3) ? stc_pkg::AS_IDLE : stc_pkg::AS_MUL;
      stc_pkg::AS_DIV: st_nxt = (cnt_r == 6'd63) ? stc_pkg::AS_IDLE : stc_pkg::AS_DIV;
      default:         st_nxt = stc_pkg::AS_IDLE;
    endcase
  end

  always_comb begin
    case (req.op)
      stc_pkg::UOP_ADD: simple_res = opa + opb;
      stc_pkg::UOP_SUB: simple_res = opa - opb;
      stc_pkg::UOP_ASR: simple_res = 64'($signed(opa) >>> req.sh);
      stc_pkg::UOP_SHL: simple_res = opa << req.sh;
      default:          simple_res = 64'd0;
    endcase
    // pick the partial product for this step
    case (cnt_r[1:0])
      2'd0:    begin mx = a_r[31:0];  my = b_r[31:0];  end
      2'd1:    begin mx = a_r[31:0];  my = b_r[63:32]; end
      default: begin mx = a_r[63:32]; my = b_r[31:0];  end
    endcase
    mul_p   = 64'(mx) * 64'(my);
    acc_fin = acc_r + {prod_r[31:0], 32'd0};
    rem_sh  = {rem_r[62:0], q_r[63]};
    ge      = (rem_sh >= mb_r);
    q_sh    = {q_r[62:0], ge};
    q_fin   = neg_r ? (64'd0 - q_sh) : q_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= stc_pkg::AS_IDLE;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      st_r   <= st_nxt;
      done_r <= 1'b0;
      case (st_r)
        stc_pkg::AS_IDLE: begin
          if (req.start) begin
            w32_r <= req.w32;
            a_r   <= opa;
            b_r   <= opb;
            cnt_r <= 6'd0;
            rem_r <= 64'd0;
            neg_r <= opa[63] ^ opb[63];
            q_r   <= opa[63] ? (64'd0 - opa) : opa;
            mb_r  <= opb[63] ? (64'd0 - opb) : opb;
            if (req.op != stc_pkg::UOP_MUL && req.op != stc_pkg::UOP_DIV) begin
              res_r  <= fix(simple_res, req.w32);
              done_r <= 1'b1;
            end
          end
        end
        stc_pkg::AS_MUL: begin
          cnt_r  <= cnt_r + 6'd1;
          prod_r <= mul_p;
          case (cnt_r[1:0])
            2'd0:    ;
            2'd1:    acc_r <= prod_r;
            2'd2:    acc_r <= acc_fin;
            default: begin
              res_r  <= fix(acc_fin, w32_r);
              done_r <= 1'b1;
            end
          endcase
        end
        stc_pkg::AS_DIV: begin
          cnt_r <= cnt_r + 6'd1;
          rem_r <= ge ? (rem_sh - mb_r) : rem_sh;
          q_r   <= q_sh;
          if (cnt_r == 6'd63) begin
            res_r  <= fix(q_fin, w32_r);
            done_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

>>> sv/sensor_thp_compensation.sv
// Top level of the temperature / pressure / humidity trim compensation block:
// channels, trim registers, scratch register file and micro-program sequencer.
// Depends on stc_pkg and stc_alu.
//
//  channel | ports                               | beat
//  --------+-------------------------------------+--------------------------------
//  input   | in_tvalid, in_tready, in_tdata      | one raw T/P/H triple
//  result  | out_tvalid, out_tready, out_tdata,  | compensated triple and flags
//          | out_tuser                           |
//  config  | cfg_we, cfg_index, cfg_wdata        | one trim register write
//
// Each beat runs a micro-program on the shared ALU: each step passes through
// fetch, issue and wait, a section end through fetch and issue only, and the
// section of a skipped field is not run. in_tready is high only
// while the sequencer is idle. The finished result sits in an output register,
// so a stalled output delays the next beat only once that register is full.
// Reset clears control state, fine temperature and the trim registers.
module sensor_thp_compensation (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // adc_temp[19:0], adc_press[39:20], adc_hum[55:40]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // temperature[31:0], pressure[63:32], humidity[80:64]
  output logic [3:0]  out_tuser,  // temp_skipped, press_skipped, hum_skipped, press_zero_div
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_wdata
);

  stc_pkg::seq_st_t state_r, state_nxt;
  logic [6:0]  pc_r, pc_nxt;
  stc_pkg::uinst_t uc;

  logic [47:0] cal_t_r, cal_pa_r, cal_pb_r, cal_pc_r;
  logic [31:0] cal_ha_r;
  logic [39:0] cal_hb_r;
  logic [19:0] adt_r, adp_r;
  logic [15:0] adh_r;
  logic        ts_r, ps_r, hs_r, zd_r;
  logic [31:0] fine_temp_r, t_res_r, p_res_r;
  logic [16:0] h_res_r;

  logic [63:0] rf [16];
  logic [63:0] rd_a_r, rd_b_r, op_a, op_b, alu_res;
  logic        alu_done;
  stc_pkg::alu_req_t alu_req;

  logic        out_valid_r;
  logic [31:0] out_t_r, out_p_r;
  logic [16:0] out_h_r;
  logic [3:0]  out_flags_r;

  logic        in_acc, ts_i, ps_i, hs_i, end_more, zd_hit, out_load;
  logic [6:0]  first_pc, end_pc;

  assign uc     = stc_pkg::ucode(pc_r);
  assign in_acc = in_tvalid && in_tready;
  assign ts_i   = (in_tdata[19:0] == stc_pkg::TEMP_SKIP);
  assign ps_i   = (in_tdata[39:20] == stc_pkg::PRESS_SKIP);
  assign hs_i   = (in_tdata[55:40] == stc_pkg::HUM_SKIP);
  assign first_pc = !ts_i ? stc_pkg::PC_TEMP : (!ps_i ? stc_pkg::PC_PRESS : stc_pkg::PC_HUM);
  assign zd_hit   = (uc.op == stc_pkg::UOP_DIV) && (op_b == 64'd0);
  assign out_load = (state_r == stc_pkg::SEQ_OUT) && (!out_valid_r || out_tready);

  function automatic logic [63:0] sx16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] sx8(logic [7:0] v);
    return {{56{v[7]}}, v};
  endfunction

  // operand other than a scratch register
  function automatic logic [63:0] spec(logic [5:0] code);
    logic [63:0] v;
    case (code)
      stc_pkg::SRC_T1:       v = {48'd0, cal_t_r[15:0]};
      stc_pkg::SRC_T2:       v = sx16(cal_t_r[31:16]);
      stc_pkg::SRC_T3:       v = sx16(cal_t_r[47:32]);
      stc_pkg::SRC_P1:       v = {48'd0, cal_pa_r[15:0]};
      stc_pkg::SRC_P2:       v = sx16(cal_pa_r[31:16]);
      stc_pkg::SRC_P3:       v = sx16(cal_pa_r[47:32]);
      stc_pkg::SRC_P4:       v = sx16(cal_pb_r[15:0]);
      stc_pkg::SRC_P5:       v = sx16(cal_pb_r[31:16]);
      stc_pkg::SRC_P6:       v = sx16(cal_pb_r[47:32]);
      stc_pkg::SRC_P7:       v = sx16(cal_pc_r[15:0]);
      stc_pkg::SRC_P8:       v = sx16(cal_pc_r[31:16]);
      stc_pkg::SRC_P9:       v = sx16(cal_pc_r[47:32]);
      stc_pkg::SRC_H1:       v = {56'd0, cal_ha_r[7:0]};
      stc_pkg::SRC_H2:       v = sx16(cal_ha_r[23:8]);
      stc_pkg::SRC_H3:       v = sx8(cal_ha_r[31:24]);
      stc_pkg::SRC_H4:       v = sx16(cal_hb_r[15:0]);
      stc_pkg::SRC_H5:       v = sx16(cal_hb_r[31:16]);
      stc_pkg::SRC_H6:       v = sx8(cal_hb_r[39:32]);
      stc_pkg::SRC_ADT:      v = {44'd0, adt_r};
      stc_pkg::SRC_ADP:      v = {44'd0, adp_r};
      stc_pkg::SRC_ADH:      v = {48'd0, adh_r};
      stc_pkg::SRC_FINE:     v = {{32{fine_temp_r[31]}}, fine_temp_r};
      stc_pkg::SRC_C1:       v = 64'd1;
      stc_pkg::SRC_C5:       v = 64'd5;
      stc_pkg::SRC_C128:     v = 64'd128;
      stc_pkg::SRC_C128000:  v = 64'd128000;
      stc_pkg::SRC_C1048576: v = 64'd1048576;
      stc_pkg::SRC_C3125:    v = 64'd3125;
      stc_pkg::SRC_C76800:   v = 64'd76800;
      stc_pkg::SRC_C2097152: v = 64'd2097152;
      stc_pkg::SRC_C16384:   v = 64'd16384;
      stc_pkg::SRC_C8192:    v = 64'd8192;
      stc_pkg::SRC_C32768:   v = 64'd32768;
      default:               v = 64'd0;
    endcase
    return v;
  endfunction

  assign op_a = (uc.a < 6'd16) ? rd_a_r : spec(uc.a);
  assign op_b = (uc.b < 6'd16) ? rd_b_r : spec(uc.b);

  // where a section end leads
  always_comb begin
    if (pc_r < stc_pkg::PC_PRESS) begin
      end_more = !ps_r || !hs_r;
      end_pc   = !ps_r ? stc_pkg::PC_PRESS : stc_pkg::PC_HUM;
    end else if (pc_r < stc_pkg::PC_HUM) begin
      end_more = !hs_r;
      end_pc   = stc_pkg::PC_HUM;
    end else begin
      end_more = 1'b0;
      end_pc   = stc_pkg::PC_HUM;
    end
  end

  // next state
  always_comb begin
    case (state_r)
      stc_pkg::SEQ_IDLE: begin
        if (in_acc) begin
          state_nxt = (!ts_i || !ps_i || !hs_i) ? stc_pkg::SEQ_FETCH : stc_pkg::SEQ_OUT;
        end else begin
          state_nxt = stc_pkg::SEQ_IDLE;
        end
      end
      stc_pkg::SEQ_FETCH: state_nxt = stc_pkg::SEQ_ISSUE;
      stc_pkg::SEQ_ISSUE: begin
        if (uc.op == stc_pkg::UOP_END) begin
          state_nxt = end_more ? stc_pkg::SEQ_FETCH : stc_pkg::SEQ_OUT;
        end else if (zd_hit) begin
          state_nxt = !hs_r ? stc_pkg::SEQ_FETCH : stc_pkg::SEQ_OUT;
        end else begin
          state_nxt = stc_pkg::SEQ_WAIT;
        end
      end
      stc_pkg::SEQ_WAIT: state_nxt = alu_done ? stc_pkg::SEQ_FETCH : stc_pkg::SEQ_WAIT;
      stc_pkg::SEQ_OUT:  state_nxt = out_load ? stc_pkg::SEQ_IDLE : stc_pkg::SEQ_OUT;
      default:           state_nxt = stc_pkg::SEQ_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready     = (state_r == stc_pkg::SEQ_IDLE);
    pc_nxt        = pc_r;
    alu_req.start = 1'b0;
    alu_req.op    = uc.op;
    alu_req.sh    = uc.sh;
    alu_req.w32   = uc.w32;
    case (state_r)
      stc_pkg::SEQ_IDLE: pc_nxt = first_pc;
      stc_pkg::SEQ_ISSUE: begin
        if (uc.op == stc_pkg::UOP_END) begin
          pc_nxt = end_pc;
        end else if (zd_hit) begin
          pc_nxt = stc_pkg::PC_HUM;
        end else begin
          alu_req.start = 1'b1;
        end
      end
      stc_pkg::SEQ_WAIT: begin
        if (alu_done) begin
          pc_nxt = pc_r + 7'd1;
        end
      end
      default: ;
    endcase
  end

  stc_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .opa    (op_a),
    .opb    (op_b),
    .done   (alu_done),
    .result (alu_res)
  );

  // scratch register file, registered reads
  always_ff @(posedge clk) begin
    if (state_r == stc_pkg::SEQ_WAIT && alu_done) begin
      rf[uc.dst] <= alu_res;
    end
    if (state_r == stc_pkg::SEQ_FETCH) begin
      rd_a_r <= rf[uc.a[3:0]];
      rd_b_r <= rf[uc.b[3:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stc_pkg::SEQ_IDLE;
      pc_r        <= stc_pkg::PC_TEMP;
      fine_temp_r <= 32'd0;
      cal_t_r     <= 48'd0;
      cal_pa_r    <= 48'd0;
      cal_pb_r    <= 48'd0;
      cal_pc_r    <= 48'd0;
      cal_ha_r    <= 32'd0;
      cal_hb_r    <= 40'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      if (cfg_we) begin
        case (cfg_index)
          stc_pkg::CFG_TEMP:    cal_t_r  <= cfg_wdata;
          stc_pkg::CFG_PRESS_A: cal_pa_r <= cfg_wdata;
          stc_pkg::CFG_PRESS_B: cal_pb_r <= cfg_wdata;
          stc_pkg::CFG_PRESS_C: cal_pc_r <= cfg_wdata;
          stc_pkg::CFG_HUM_A:   cal_ha_r <= cfg_wdata[31:0];
          stc_pkg::CFG_HUM_B:   cal_hb_r <= cfg_wdata[39:0];
          default: ;
        endcase
      end
      if (state_r == stc_pkg::SEQ_WAIT && alu_done && uc.tgt == stc_pkg::TGT_FINE) begin
        fine_temp_r <= alu_res[31:0];
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // per-item payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      adt_r   <= in_tdata[19:0];
      adp_r   <= in_tdata[39:20];
      adh_r   <= in_tdata[55:40];
      ts_r    <= ts_i;
      ps_r    <= ps_i;
      hs_r    <= hs_i;
      zd_r    <= 1'b0;
      t_res_r <= 32'd0;
      p_res_r <= 32'd0;
      h_res_r <= 17'd0;
    end
    if (state_r == stc_pkg::SEQ_ISSUE && uc.op != stc_pkg::UOP_END && zd_hit) begin
      zd_r <= 1'b1;
    end
    if (state_r == stc_pkg::SEQ_WAIT && alu_done) begin
      case (uc.tgt)
        stc_pkg::TGT_TEMP:  t_res_r <= alu_res[31:0];
        stc_pkg::TGT_PRESS: p_res_r <= alu_res[31:0];
        stc_pkg::TGT_HUM: begin
          // clamp to 0..100 percent, then drop 12 of the 22 fraction bits
          if (alu_res[31]) begin
            h_res_r <= 17'd0;
          end else if (alu_res[31:0] > stc_pkg::HUM_MAX) begin
            h_res_r <= stc_pkg::HUM_MAX_Q;
          end else begin
            h_res_r <= alu_res[28:12];
          end
        end
        default: ;
      endcase
    end
    if (out_load) begin
      out_t_r     <= t_res_r;
      out_p_r     <= p_res_r;
      out_h_r     <= h_res_r;
      out_flags_r <= {zd_r, hs_r, ps_r, ts_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_h_r, out_p_r, out_t_r};
  assign out_tuser  = out_flags_r;

`ifndef ASSERT_OFF
  a_alu_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    alu_done |-> state_r == stc_pkg::SEQ_WAIT)
    else $error("ALU finished outside of wait");

  a_zdiv_press_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[3]) |-> (out_tdata[63:32] == 32'd0 && !out_tuser[1]))
    else $error("zero divisor with nonzero pressure");

  a_tskip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> out_tdata[31:0] == 32'd0)
    else $error("skipped temperature not zero");

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[80:64] <= stc_pkg::HUM_MAX_Q)
    else $error("humidity out of range");

  a_fine_hold_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != stc_pkg::SEQ_IDLE && ts_r) |=> $stable(fine_temp_r))
    else $error("fine temperature moved on skipped beat");
`endif

endmodule
